/* rtl/khld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// khld_pkg: shared constants and types
// Round constants, initial hash words and register indexes for the
// keyed hash loss decider.
// ----------------------------------------------------------------------------
package khld_pkg;

	localparam logic [2:0] REG_SEED0   = 3'd0;
	localparam logic [2:0] REG_SEED1   = 3'd1;
	localparam logic [2:0] REG_SEED2   = 3'd2;
	localparam logic [2:0] REG_SEED3   = 3'd3;
	localparam logic [2:0] REG_WSTART  = 3'd4;
	localparam logic [2:0] REG_WEND    = 3'd5;
	localparam logic [2:0] REG_DIR     = 3'd6;
	localparam logic [2:0] REG_ENABLE  = 3'd7;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [6:0] DROP_MODULUS = 7'd100;

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// "loss-recovery-v1" followed by a zero byte
	localparam logic [135:0] MSG_TAG = 136'h6c6f73732d7265636f766572792d763100;

	typedef struct packed {
		logic        start;
		logic [511:0] block;
		logic [255:0] chain;
	} sha_req_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
				6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
				6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
				6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
				6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
				6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
				6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
				6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
				6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
				6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
				6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
				6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
				6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
				6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
				6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
				6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
				6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
				6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
				6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
				6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
				6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
				6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
				6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
				6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
				6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
				6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
				6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
				6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
				6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
				6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
				6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
				6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
				default: k = 32'h0;
			endcase
			return k;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/khld_sha_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// khld_sha_core: one SHA-256 compression, one round per cycle
// Message schedule kept in a sixteen-word sliding window.
// ----------------------------------------------------------------------------
module khld_sha_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire khld_pkg::sha_req_t req,
	output logic                   done,
	output logic [255:0]           digest
);

	logic [511:0] w_q;
	logic [255:0] v_q;
	logic [255:0] chain_q;
	logic [5:0]   rnd_q;
	logic         busy_q;

	logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14;
	logic [31:0] s0, s1, t1, t2, ws0, ws1, wnew;

	assign {a, b, c, d, e, f, g, h} = v_q;
	assign w0  = w_q[511:480];
	assign w1  = w_q[479:448];
	assign w9  = w_q[223:192];
	assign w14 = w_q[63:32];

	always_comb begin
		s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		t1 = h + s1 + ((e & f) ^ (~e & g)) + khld_pkg::round_k(rnd_q) + w0;
		t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
		ws0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b0, w1[31:3]};
		ws1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'b0, w14[31:10]};
		wnew = w0 + ws0 + w9 + ws1;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			digest[32*i +: 32] = chain_q[32*i +: 32] + v_q[32*i +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			w_q     <= req.block;
			v_q     <= req.chain;
			chain_q <= req.chain;
		end else if (busy_q) begin
			w_q <= {w_q[479:0], wnew};
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
		end
	end

endmodule
`default_nettype wire

/* rtl/keyed_hash_loss_decider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_hash_loss_decider: deterministic per-packet drop decision
// Keyed SHA-256 over a message of tag, phase, direction and counter, reduced modulo 100.
// ----------------------------------------------------------------------------
// Usage: a packet timestamp arrives as one item on the s_axis channel
// (64-bit tdata). Exactly one result item leaves on m_axis, four flag bits in
// tdata. Registers are written on the cfg channel (index 0 to 7) while idle.
// An item that is not active, or whose counter is exhausted, has its result
// item valid in the cycle after acceptance. An active item runs four
// compressions on the one shared round unit, each made of a start step, 64
// rounds and collection of the digest; then the 256-bit digest is reduced one
// byte a cycle over its 32 bytes, and the result item is valid after the
// last byte. One item is in flight at a time, and s_axis_tready stays low
// from acceptance until the result item has been taken. When the receiver
// stalls, the result item holds in its output register. Reset clears all
// registers and both phase counters, disarms the block and leaves it ready
// at once.
// ----------------------------------------------------------------------------
module keyed_hash_loss_decider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] now_ns
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // bit 0 active, 1 in_measurement, 2 drop,
	                                          // 3 count_exhausted, 7:4 zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_HASH, ST_WAIT, ST_REDUCE, ST_OUT
	} state_t;

	state_t       state_q;
	logic [255:0] seed_q;
	logic [63:0]  wstart_q, wend_q, cnt_q [2];
	logic         dir_q, en_q;
	logic         phase_q;
	logic [1:0]   blk_q;
	logic [255:0] chain_q, inner_q, dig_q;
	logic [4:0]   byte_q;
	logic [6:0]   rem_q;
	logic [3:0]   res_q;

	khld_pkg::sha_req_t req;
	logic         core_done;
	logic [255:0] core_dig;

	khld_sha_core u_core (
		.clk(clk), .arst_n(arst_n), .req(req), .done(core_done), .digest(core_dig)
	);

	// Pad blocks: key xor ipad/opad, then the two message blocks.
	logic [511:0] ipad_blk, opad_blk, msg_blk, out_blk;
	assign ipad_blk = {seed_q, 256'h0} ^ {64{khld_pkg::IPAD_BYTE}};
	assign opad_blk = {seed_q, 256'h0} ^ {64{khld_pkg::OPAD_BYTE}};
	// 64 + 27 = 91 bytes, length 728 bits.
	assign msg_blk = {khld_pkg::MSG_TAG, 7'b0, phase_q, 7'b0, dir_q,
		cnt_q[phase_q], khld_pkg::PAD_MARK, 224'h0, 64'd728};
	// 64 + 32 = 96 bytes, length 768 bits.
	assign out_blk = {inner_q, khld_pkg::PAD_MARK, 184'h0, 64'd768};

	always_comb begin
		req.start = (state_q == ST_HASH);
		req.chain = chain_q;
		case (blk_q)
			2'd0: req.block = ipad_blk;
			2'd1: req.block = msg_blk;
			2'd2: req.block = opad_blk;
			default: req.block = out_blk;
		endcase
	end

	// Reduction step: (rem*256 + byte) mod 100, value below 25600.
	logic [14:0] acc;
	logic [7:0]  cur_byte;
	assign cur_byte = dig_q[255:248];
	assign acc = {rem_q, 8'h0} + {7'h0, cur_byte};
	// Exact mod by reciprocal: q = floor(acc*5243 >> 19) for acc < 25600.
	logic [27:0] qprod;
	logic [14:0] qv, rm;
	always_comb begin
		qprod = 28'(acc) * 28'd5243;
		qv = 15'(qprod >> 19);
		rm = acc - 15'(qv * 15'd100);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {4'b0, res_q[0], res_q[1], res_q[2], res_q[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			seed_q   <= '0;
			wstart_q <= '0;
			wend_q   <= '0;
			dir_q    <= 1'b0;
			en_q     <= 1'b0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			blk_q    <= '0;
			res_q    <= '0;
			phase_q  <= 1'b0;
			chain_q  <= '0;
			inner_q  <= '0;
			dig_q    <= '0;
			byte_q   <= '0;
			rem_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					khld_pkg::REG_SEED0: seed_q[255:192] <= cfg_data;
					khld_pkg::REG_SEED1: seed_q[191:128] <= cfg_data;
					khld_pkg::REG_SEED2: seed_q[127:64]  <= cfg_data;
					khld_pkg::REG_SEED3: seed_q[63:0]    <= cfg_data;
					khld_pkg::REG_WSTART: wstart_q <= cfg_data;
					khld_pkg::REG_WEND:   wend_q   <= cfg_data;
					khld_pkg::REG_DIR:    dir_q    <= cfg_data[0];
					khld_pkg::REG_ENABLE: begin
						if (!cfg_data[0]) begin
							en_q <= 1'b0;
						end else if (wstart_q != 64'h0 && wstart_q < wend_q) begin
							en_q     <= 1'b1;
							cnt_q[0] <= '0;
							cnt_q[1] <= '0;
						end
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						// res_q bits: 3 active, 2 in_measurement, 1 drop, 0 exhausted
						if (!en_q || s_axis_tdata >= wend_q) begin
							res_q   <= 4'b0;
							state_q <= ST_OUT;
						end else begin
							phase_q <= (s_axis_tdata >= wstart_q);
							if (cnt_q[s_axis_tdata >= wstart_q] == '1) begin
								res_q   <= {1'b1, s_axis_tdata >= wstart_q, 2'b01};
								state_q <= ST_OUT;
							end else begin
								res_q   <= {1'b1, s_axis_tdata >= wstart_q, 2'b00};
								blk_q   <= 2'd0;
								chain_q <= khld_pkg::H_INIT;
								state_q <= ST_HASH;
							end
						end
					end
				end
				ST_HASH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (core_done) begin
						blk_q <= blk_q + 2'd1;
						case (blk_q)
							2'd0, 2'd2: begin
								chain_q <= core_dig;
								state_q <= ST_HASH;
							end
							2'd1: begin
								inner_q <= core_dig;
								chain_q <= khld_pkg::H_INIT;
								state_q <= ST_HASH;
							end
							default: begin
								dig_q   <= core_dig;
								rem_q   <= '0;
								byte_q  <= '0;
								state_q <= ST_REDUCE;
							end
						endcase
					end
				end
				ST_REDUCE: begin
					rem_q  <= rm[6:0];
					dig_q  <= {dig_q[247:0], 8'h0};
					byte_q <= byte_q + 5'd1;
					if (byte_q == 5'd31) begin
						res_q[1] <= (rm[6:0] == 7'd0);
						cnt_q[phase_q] <= cnt_q[phase_q] + 64'd1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0])
		else $error("flag set on an inactive result");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
		else $error("drop with exhausted counter");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE) |-> rem_q < khld_pkg::DROP_MODULUS)
		else $error("remainder out of range");

endmodule
`default_nettype wire
